FILE: rtl/core/spwm3h_pkg.sv
// ----------------------------------------------------------------------------
// spwm3h_pkg: shared types and constants of the three-phase SPWM core
// Table geometry, item codes, register indexes, datapath widths and the
// final duty offset and saturation step.
// ----------------------------------------------------------------------------
package spwm3h_pkg;

	// table geometry
	localparam int TABLE_LEN  = 1200;
	localparam int IDX_W      = $clog2(TABLE_LEN);
	localparam int I0_W       = $clog2(TABLE_LEN + 1);
	localparam int THIRD_TURN = TABLE_LEN / 3;

	// field widths
	localparam int PHASE_W = 32;
	localparam int SCALE_W = PHASE_W + I0_W;
	localparam int ADDR_W  = 11;
	localparam int VAL_W   = 16;
	localparam int K_W     = 16;
	localparam int DUTY_W  = 16;

	// item codes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SINE = 2'd1;
	localparam logic [1:0] MODE_HARM = 2'd2;

	// register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_INDEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFFSET = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd14316558;
	localparam logic [K_W-1:0]     RECT_INDEX_RST  = 16'd6554;
	localparam logic [DUTY_W-1:0]  DUTY_OFFSET_RST = 16'd1050;

	// duty datapath: k * (6s + h) / (3 * 2^15), truncated toward zero
	localparam int SUM_W       = 19;
	localparam int PROD_W      = 36;
	localparam int DIV_SHIFT   = 15;
	localparam int Q_W         = 19;
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_3 = 20'd699051;	// ceil(2^21 / 3)
	localparam int RECIP_SHIFT = 21;
	localparam int QUO_W       = 18;
	localparam int DSUM_W      = 20;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 16'hFFFF;

	// stage load enables handed to the duty lanes
	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
	} spwm3h_adv_t;

	// offset plus signed quotient, clamped to the compare range
	function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] offset,
			input logic [QUO_W-1:0] quo, input logic neg);
		logic signed [DSUM_W-1:0] term;
		logic signed [DSUM_W-1:0] d;
		term = signed'(DSUM_W'(quo));
		if (neg) begin
			term = -term;
		end
		d = signed'(DSUM_W'(offset)) + term;
		if (d[DSUM_W-1]) begin
			sat_duty = '0;
		end else if (d > signed'(DSUM_W'(DUTY_MAX))) begin
			sat_duty = DUTY_MAX;
		end else begin
			sat_duty = d[DUTY_W-1:0];
		end
	endfunction

endpackage

FILE: rtl/core/spwm3h_ram.sv
// ----------------------------------------------------------------------------
// spwm3h_ram: simple dual-port table memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spwm3h_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1200
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/spwm3h_index.sv
// ----------------------------------------------------------------------------
// spwm3h_index: phase to table index
// Scales the phase to a rounded table index, registers it, then forms the
// three read addresses 120 degrees apart.
// ----------------------------------------------------------------------------
module spwm3h_index (
	input  logic                              clk,
	input  logic                              ld_s2,
	input  logic [spwm3h_pkg::PHASE_W-1:0]    phase_s1,
	output logic [spwm3h_pkg::IDX_W-1:0]      addr_a,
	output logic [spwm3h_pkg::IDX_W-1:0]      addr_b,
	output logic [spwm3h_pkg::IDX_W-1:0]      addr_c
);
	import spwm3h_pkg::*;

	localparam logic [SCALE_W-1:0] HALF_STEP = SCALE_W'(64'h8000_0000);

	logic [SCALE_W-1:0] scaled;
	logic [I0_W-1:0]    i0_s2;
	logic [I0_W-1:0]    base;
	logic [I0_W:0]      sum_b;
	logic [I0_W:0]      sum_c;

	// phase * TABLE_LEN, rounded to the nearest entry
	assign scaled = SCALE_W'(phase_s1) * SCALE_W'(TABLE_LEN) + HALF_STEP;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			i0_s2 <= scaled[SCALE_W-1:PHASE_W];
		end
	end

	// a full turn wraps to entry zero; other phases offset by a third turn
	always_comb begin
		base  = (i0_s2 >= I0_W'(TABLE_LEN)) ? '0 : i0_s2;
		sum_b = (I0_W+1)'(base) + (I0_W+1)'(THIRD_TURN);
		sum_c = (I0_W+1)'(base) + (I0_W+1)'(2 * THIRD_TURN);
		if (sum_b >= (I0_W+1)'(TABLE_LEN)) begin
			sum_b = sum_b - (I0_W+1)'(TABLE_LEN);
		end
		if (sum_c >= (I0_W+1)'(TABLE_LEN)) begin
			sum_c = sum_c - (I0_W+1)'(TABLE_LEN);
		end
	end

	assign addr_a = base[IDX_W-1:0];
	assign addr_b = sum_b[IDX_W-1:0];
	assign addr_c = sum_c[IDX_W-1:0];

endmodule

FILE: rtl/core/spwm3h_duty.sv
// ----------------------------------------------------------------------------
// spwm3h_duty: compare values of one phase
// Four stages from the table words to the inverter and rectifier duties:
// mix, scale, magnitude and shift, reciprocal divide by three and clamp.
// ----------------------------------------------------------------------------
module spwm3h_duty (
	input  logic                                  clk,
	input  spwm3h_pkg::spwm3h_adv_t               adv,
	input  logic signed [spwm3h_pkg::VAL_W-1:0]   sine_s3,
	input  logic signed [spwm3h_pkg::VAL_W-1:0]   harm_s3,
	input  logic [spwm3h_pkg::K_W-1:0]            kinv_s3,
	input  logic [spwm3h_pkg::K_W-1:0]            krec_s3,
	input  logic [spwm3h_pkg::DUTY_W-1:0]         duty_offset,
	output logic [spwm3h_pkg::DUTY_W-1:0]         duty_inv,
	output logic [spwm3h_pkg::DUTY_W-1:0]         duty_rec
);
	import spwm3h_pkg::*;

	// lane 0 inverter, lane 1 rectifier
	logic signed [SUM_W-1:0]       sum_s4;
	logic [K_W-1:0]                k_s4    [2];
	logic signed [PROD_W-1:0]      prod_s5 [2];
	logic [PROD_W-1:0]             mag     [2];
	logic [Q_W-1:0]                q_s6    [2];
	logic                          neg_s6  [2];
	logic [Q_W+RECIP_W-1:0]        recip   [2];
	logic [DUTY_W-1:0]             duty_s7 [2];

	// 6s + h
	always_ff @(posedge clk) begin
		if (adv.ld_s4) begin
			sum_s4  <= (SUM_W'(sine_s3) <<< 2) + (SUM_W'(sine_s3) <<< 1) + SUM_W'(harm_s3);
			k_s4[0] <= kinv_s3;
			k_s4[1] <= krec_s3;
		end
	end

	// scale by the modulation index
	always_ff @(posedge clk) begin
		if (adv.ld_s5) begin
			for (int l = 0; l < 2; l++) begin
				prod_s5[l] <= $signed({1'b0, k_s4[l]}) * sum_s4;
			end
		end
	end

	// magnitude, divide by 2^15
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l] = prod_s5[l][PROD_W-1] ? PROD_W'(-prod_s5[l]) : PROD_W'(prod_s5[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s6) begin
			for (int l = 0; l < 2; l++) begin
				q_s6[l]   <= mag[l][DIV_SHIFT+Q_W-1:DIV_SHIFT];
				neg_s6[l] <= prod_s5[l][PROD_W-1];
			end
		end
	end

	// divide by three through the reciprocal, restore sign, offset, clamp
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			recip[l] = (Q_W+RECIP_W)'(q_s6[l]) * (Q_W+RECIP_W)'(RECIP_3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s7) begin
			for (int l = 0; l < 2; l++) begin
				duty_s7[l] <= sat_duty(duty_offset,
					recip[l][RECIP_SHIFT+QUO_W-1:RECIP_SHIFT], neg_s6[l]);
			end
		end
	end

	assign duty_inv = duty_s7[0];
	assign duty_rec = duty_s7[1];

endmodule

FILE: rtl/core/three_phase_spwm_third_harmonic_core.sv
// ----------------------------------------------------------------------------
// three_phase_spwm_third_harmonic_core: three-phase sine PWM with injection
//
// Input channel (in_valid/in_ready): mode selects a tick or a table load.
// A load writes one sine or third-harmonic entry and gives no result; a
// load beyond the table and the unused mode are dropped. A tick advances
// the phase by phase_step and gives one item of six compare values
// (inverter and rectifier, phases A, B, C) on the output channel
// (out_valid/out_ready). Configuration writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data) are always taken and belong in idle periods.
// Throughput: one item per cycle while the output is not stalled; each
// phase owns one copy of both tables, read once per tick through its
// single read port, and load items write all copies in pipeline order.
// Reset clears the phase, the pipeline and loads the register defaults;
// the tables keep their contents and must be loaded before use.
// A stalled receiver holds the output register; the pipeline keeps taking
// items until all seven stages are full, then in_ready drops.
// ----------------------------------------------------------------------------
module three_phase_spwm_third_harmonic_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spwm3h_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spwm3h_pkg::PHASE_W-1:0]        cfg_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic [spwm3h_pkg::ADDR_W-1:0]         table_addr,
	input  logic signed [spwm3h_pkg::VAL_W-1:0]   table_value,
	input  logic [spwm3h_pkg::K_W-1:0]            inverter_index,
	input  logic                                  startup_done,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [spwm3h_pkg::DUTY_W-1:0]         inverter_duty_a,
	output logic [spwm3h_pkg::DUTY_W-1:0]         inverter_duty_b,
	output logic [spwm3h_pkg::DUTY_W-1:0]         inverter_duty_c,
	output logic [spwm3h_pkg::DUTY_W-1:0]         rectifier_duty_a,
	output logic [spwm3h_pkg::DUTY_W-1:0]         rectifier_duty_b,
	output logic [spwm3h_pkg::DUTY_W-1:0]         rectifier_duty_c
);
	import spwm3h_pkg::*;

	// configuration and phase
	logic [PHASE_W-1:0] phase_step_q;
	logic [K_W-1:0]     rect_index_q;
	logic [DUTY_W-1:0]  duty_offset_q;
	logic [PHASE_W-1:0] phase_acc_q;

	// pipeline
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;
	logic               rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	logic               tick_s1, tick_s2, harm_s1, harm_s2;
	logic [PHASE_W-1:0] phase_s1;
	logic [ADDR_W-1:0]  waddr_s1, waddr_s2;
	logic [VAL_W-1:0]   wval_s1, wval_s2;
	logic [K_W-1:0]     kinv_s1, kinv_s2, kinv_s3;
	logic [K_W-1:0]     krec_s1, krec_s2, krec_s3;
	logic               tick_acc;
	logic               load_ok;
	logic               we_sine, we_harm, rd_en;
	logic [IDX_W-1:0]   rd_addr [3];
	logic [VAL_W-1:0]   sine_rd [3];
	logic [VAL_W-1:0]   harm_rd [3];
	logic [DUTY_W-1:0]  duty_inv [3];
	logic [DUTY_W-1:0]  duty_rec [3];
	spwm3h_adv_t        adv;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= PHASE_STEP_RST;
			rect_index_q  <= RECT_INDEX_RST;
			duty_offset_q <= DUTY_OFFSET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PHASE_STEP:  phase_step_q  <= cfg_data;
				REG_RECT_INDEX:  rect_index_q  <= cfg_data[K_W-1:0];
				REG_DUTY_OFFSET: duty_offset_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// stage ready chain
	assign rdy_s7 = !out_valid_q || out_ready;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign adv = '{ld_s4: rdy_s4, ld_s5: rdy_s5, ld_s6: rdy_s6, ld_s7: rdy_s7};

	// phase accumulator moves on accepted ticks only
	assign tick_acc = in_valid && in_ready && (mode == MODE_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (tick_acc) begin
			phase_acc_q <= phase_acc_q + phase_step_q;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid && (mode == MODE_TICK || mode == MODE_SINE ||
					mode == MODE_HARM);
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2 && tick_s2;	// loads retire at the table write
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_s6) begin
				v_s6 <= v_s5;
			end
			if (rdy_s7) begin
				out_valid_q <= v_s6;
			end
		end
	end

	// stage 1 payload: new phase and item fields
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			phase_s1 <= phase_acc_q + phase_step_q;
			tick_s1  <= (mode == MODE_TICK);
			harm_s1  <= (mode == MODE_HARM);
			waddr_s1 <= table_addr;
			wval_s1  <= table_value;
			kinv_s1  <= inverter_index;
			krec_s1  <= startup_done ? rect_index_q : inverter_index;
		end
	end

	// stage 2 payload; the index itself is registered in the index unit
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			tick_s2  <= tick_s1;
			harm_s2  <= harm_s1;
			waddr_s2 <= waddr_s1;
			wval_s2  <= wval_s1;
			kinv_s2  <= kinv_s1;
			krec_s2  <= krec_s1;
		end
	end

	spwm3h_index u_index (
		.clk      (clk),
		.ld_s2    (rdy_s2),
		.phase_s1 (phase_s1),
		.addr_a   (rd_addr[0]),
		.addr_b   (rd_addr[1]),
		.addr_c   (rd_addr[2])
	);

	// table access as the item leaves stage 2, in item order
	assign load_ok = waddr_s2 < ADDR_W'(TABLE_LEN);
	assign we_sine = rdy_s3 && v_s2 && !tick_s2 && !harm_s2 && load_ok;
	assign we_harm = rdy_s3 && v_s2 && !tick_s2 && harm_s2 && load_ok;
	assign rd_en   = rdy_s3 && v_s2 && tick_s2;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			kinv_s3 <= kinv_s2;
			krec_s3 <= krec_s2;
		end
	end

	// one table copy and one duty lane per phase
	for (genvar p = 0; p < 3; p++) begin : g_phase
		spwm3h_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_LEN)) u_sine (
			.clk   (clk),
			.we    (we_sine),
			.waddr (waddr_s2[IDX_W-1:0]),
			.wdata (wval_s2),
			.re    (rd_en),
			.raddr (rd_addr[p]),
			.rdata (sine_rd[p])
		);

		spwm3h_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_LEN)) u_harm (
			.clk   (clk),
			.we    (we_harm),
			.waddr (waddr_s2[IDX_W-1:0]),
			.wdata (wval_s2),
			.re    (rd_en),
			.raddr (rd_addr[p]),
			.rdata (harm_rd[p])
		);

		spwm3h_duty u_duty (
			.clk         (clk),
			.adv         (adv),
			.sine_s3     ($signed(sine_rd[p])),
			.harm_s3     ($signed(harm_rd[p])),
			.kinv_s3     (kinv_s3),
			.krec_s3     (krec_s3),
			.duty_offset (duty_offset_q),
			.duty_inv    (duty_inv[p]),
			.duty_rec    (duty_rec[p])
		);
	end

	// outputs
	assign out_valid        = out_valid_q;
	assign inverter_duty_a  = duty_inv[0];
	assign inverter_duty_b  = duty_inv[1];
	assign inverter_duty_c  = duty_inv[2];
	assign rectifier_duty_a = duty_rec[0];
	assign rectifier_duty_b = duty_rec[1];
	assign rectifier_duty_c = duty_rec[2];

`ifndef SYNTH
	// read addresses of a tick always fall inside the table
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && tick_s2) |-> (rd_addr[0] < IDX_W'(TABLE_LEN) &&
			rd_addr[1] < IDX_W'(TABLE_LEN) && rd_addr[2] < IDX_W'(TABLE_LEN)))
		else $error("table read address out of range");

	// input only backs up when every stage holds an item and the sink stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 &&
			out_valid_q && !out_ready))
		else $error("input stalled with a free stage");

	// phase moves on accepted ticks alone
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_acc |=> $stable(phase_acc_q))
		else $error("phase changed without a tick");

	// a tick read from the tables arrives at stage 3
	a_read_follow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> v_s3)
		else $error("table read lost between stages");
`endif

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the three-phase SPWM core
// Loads both waveform tables on the grid of entries that the phase steps
// reach, then drives ticks, table loads and dropped items against a
// bit-exact predictor of the phase accumulator, the table lookup and the
// saturated duty arithmetic. Register settings change only while the core
// is idle; both handshakes are throttled at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import spwm3h_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 12;
	localparam int RUN_LIMIT_NS  = 2_000_000;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_ITEMS = 50;
	// phase steps in sixteenths of a turn put every index on a multiple of 75;
	// the other two phases add a third of the table, so reads stay on a 25 grid
	localparam int STEP_SHIFT    = 28;
	localparam int ENTRY_STRIDE  = 25;
	// 6 * 2^14: sine weight times the Q2.14 unit
	localparam longint DUTY_DIVISOR = 98304;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  value;
		logic [K_W-1:0]    k;
		logic              started;
	} spwm_item_t;

	typedef struct packed {
		logic [2:0][DUTY_W-1:0] inv;
		logic [2:0][DUTY_W-1:0] rect;
	} duty_set_t;

	typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_LONG_STALL} rx_style_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// core ports
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [PHASE_W-1:0]    cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [1:0]            mode      = MODE_TICK;
	logic [ADDR_W-1:0]     table_addr = '0;
	logic signed [VAL_W-1:0] table_value = '0;
	logic [K_W-1:0]        inverter_index = '0;
	logic                  startup_done = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DUTY_W-1:0]     inverter_duty_a, inverter_duty_b, inverter_duty_c;
	logic [DUTY_W-1:0]     rectifier_duty_a, rectifier_duty_b, rectifier_duty_c;

	three_phase_spwm_third_harmonic_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.table_addr       (table_addr),
		.table_value      (table_value),
		.inverter_index   (inverter_index),
		.startup_done     (startup_done),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inverter_duty_a  (inverter_duty_a),
		.inverter_duty_b  (inverter_duty_b),
		.inverter_duty_c  (inverter_duty_c),
		.rectifier_duty_a (rectifier_duty_a),
		.rectifier_duty_b (rectifier_duty_b),
		.rectifier_duty_c (rectifier_duty_c)
	);

	// predictor state
	logic [PHASE_W-1:0]      model_phase  = '0;
	logic [PHASE_W-1:0]      model_step   = PHASE_STEP_RST;
	logic [K_W-1:0]          model_rect_k = RECT_INDEX_RST;
	logic [DUTY_W-1:0]       model_offset = DUTY_OFFSET_RST;
	logic signed [VAL_W-1:0] sine_tab [TABLE_LEN];
	logic signed [VAL_W-1:0] harm_tab [TABLE_LEN];
	duty_set_t               expected_duties [$];

	int        error_count = 0;
	int        burst_left  = 0;
	int        rx_count    = 0;
	rx_style_t rx_style    = RX_OPEN;

	// one compare value: offset + k * (6s + h) / divisor, truncated, clamped
	function automatic logic [DUTY_W-1:0] duty_of(input logic [K_W-1:0] k, input int idx);
		longint kk, s, h, prod, d;
		kk = longint'(k);
		s = longint'(sine_tab[idx]);
		h = longint'(harm_tab[idx]);
		prod = kk * (6 * s + h);
		d = longint'(model_offset);
		d = d + prod / DUTY_DIVISOR;
		if (d < 0) begin
			d = 0;
		end else if (d > 65535) begin
			d = 65535;
		end
		return d[DUTY_W-1:0];
	endfunction

	// apply one accepted item; a tick queues the six expected duties
	function automatic void predict_duties(input spwm_item_t it);
		longint unsigned scaled;
		int base, idx;
		logic [K_W-1:0] rect_k;
		duty_set_t d;
		case (it.mode)
		MODE_SINE: begin
			if (it.addr < TABLE_LEN) sine_tab[it.addr] = it.value;
		end
		MODE_HARM: begin
			if (it.addr < TABLE_LEN) harm_tab[it.addr] = it.value;
		end
		MODE_TICK: begin
			model_phase = model_phase + model_step;
			scaled = 64'(model_phase);
			scaled = scaled * TABLE_LEN + 64'h8000_0000;
			base = int'(scaled >> 32);
			// rounding up to a full turn lands back on entry zero
			if (base >= TABLE_LEN) base = 0;
			rect_k = it.started ? model_rect_k : it.k;
			for (int p = 0; p < 3; p++) begin
				idx = (base + p * THIRD_TURN) % TABLE_LEN;
				d.inv[p]  = duty_of(it.k, idx);
				d.rect[p] = duty_of(rect_k, idx);
			end
			expected_duties.push_back(d);
		end
		default: ;	// spare code: dropped
		endcase
	endfunction

	function automatic void check_field(input string label, input logic [DUTY_W-1:0] want,
			input logic [DUTY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, label, want, got);
			error_count++;
		end
	endfunction

	// result checker and receiver throttling
	always @(posedge clk) begin
		duty_set_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_duties.size() == 0) begin
				$display("%0t: unexpected result expected none got %h %h %h %h %h %h", $time,
					inverter_duty_a, inverter_duty_b, inverter_duty_c,
					rectifier_duty_a, rectifier_duty_b, rectifier_duty_c);
				error_count++;
			end else begin
				want = expected_duties.pop_front();
				check_field("inverter_duty_a",  want.inv[0],  inverter_duty_a);
				check_field("inverter_duty_b",  want.inv[1],  inverter_duty_b);
				check_field("inverter_duty_c",  want.inv[2],  inverter_duty_c);
				check_field("rectifier_duty_a", want.rect[0], rectifier_duty_a);
				check_field("rectifier_duty_b", want.rect[1], rectifier_duty_b);
				check_field("rectifier_duty_c", want.rect[2], rectifier_duty_c);
			end
		end
		rx_count++;
		if (rx_count % 50 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
		case (rx_style)
		RX_OPEN:   out_ready <= 1'b1;
		RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
		RX_SPARSE: out_ready <= (rx_count % 4 == 0);
		default:   out_ready <= (rx_count % 16) >= 11;
		endcase
	end

	// send one item, then maybe close the burst with a gap
	task automatic send_item(input spwm_item_t it);
		int gap;
		mode           <= it.mode;
		table_addr     <= it.addr;
		table_value    <= it.value;
		inverter_index <= it.k;
		startup_done   <= it.started;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_duties(it);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic release_input;
		in_valid <= 1'b0;
	endtask

	// wait for all duties, then for loads still in the pipeline
	task automatic await_quiet;
		while (expected_duties.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [PHASE_W-1:0] data);
		release_input();
		await_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (index)
		REG_PHASE_STEP:  model_step   = data;
		REG_RECT_INDEX:  model_rect_k = data[K_W-1:0];
		REG_DUTY_OFFSET: model_offset = data[DUTY_W-1:0];
		default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// item builders; fields the core does not use carry random bits
	function automatic spwm_item_t tick_item(input logic [K_W-1:0] k, input logic started);
		spwm_item_t it;
		it.mode    = MODE_TICK;
		it.addr    = ADDR_W'($urandom_range(0, 2047));
		it.value   = VAL_W'($urandom_range(0, 65535));
		it.k       = k;
		it.started = started;
		return it;
	endfunction

	function automatic spwm_item_t load_item(input logic [1:0] m, input int addr,
			input logic [VAL_W-1:0] value);
		spwm_item_t it;
		it.mode    = m;
		it.addr    = ADDR_W'(addr);
		it.value   = value;
		it.k       = K_W'($urandom_range(0, 65535));
		it.started = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic logic [K_W-1:0] pick_index;
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return 16'hFFFF;
		2:       return 16'd16384;
		default: return K_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value;
		case ($urandom_range(0, 9))
		0:       return 16'h7FFF;
		1:       return 16'h8000;
		2:       return 16'h0000;
		3:       return 16'hFFFF;
		default: return VAL_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// a random whole number of sixteenths of a turn
	function automatic logic [PHASE_W-1:0] pick_step;
		return PHASE_W'($urandom_range(0, 15)) << STEP_SHIFT;
	endfunction

	function automatic spwm_item_t random_item;
		int r;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			return tick_item(pick_index(), 1'($urandom_range(0, 1)));
		end else if (r < 88) begin
			return load_item((r < 80) ? MODE_SINE : MODE_HARM,
				ENTRY_STRIDE * $urandom_range(0, TABLE_LEN / ENTRY_STRIDE - 1),
				pick_value());
		end else if (r < 94) begin
			return load_item((r < 91) ? MODE_SINE : MODE_HARM,
				$urandom_range(TABLE_LEN, 2047), VAL_W'($urandom_range(0, 65535)));
		end
		return load_item(MODE_SPARE, $urandom_range(0, 2047),
			VAL_W'($urandom_range(0, 65535)));
	endfunction

	// every entry on the read grid gets a value before the first tick
	task automatic test_table_fill;
		real ang;
		int sv, hv;
		for (int a = 0; a < TABLE_LEN; a += ENTRY_STRIDE) begin
			ang = 2.0 * 3.14159265358979 * a / TABLE_LEN;
			sv = int'(30000.0 * $sin(ang)) + int'($urandom_range(0, 64)) - 32;
			hv = int'(5000.0 * $sin(3.0 * ang));
			send_item(load_item(MODE_SINE, a, VAL_W'(sv)));
			send_item(load_item(MODE_HARM, a, VAL_W'(hv)));
		end
	endtask

	// a full-turn step keeps the index on the wrap; extremes force saturation
	task automatic test_index_wrap_and_saturation;
		send_item(load_item(MODE_SINE, 0, 16'h7FFF));
		send_item(load_item(MODE_HARM, 0, 16'h7FFF));
		send_item(load_item(MODE_SINE, THIRD_TURN, 16'h8000));
		send_item(load_item(MODE_HARM, THIRD_TURN, 16'h8000));
		send_item(load_item(MODE_SINE, 2 * THIRD_TURN, 16'h0000));
		send_item(load_item(MODE_HARM, 2 * THIRD_TURN, 16'hFFFF));
		write_register(REG_PHASE_STEP, 32'hFFFF_FFFF);
		send_item(tick_item(16'hFFFF, 1'b0));
		send_item(tick_item(16'h0000, 1'b1));
		send_item(tick_item(16'hFFFF, 1'b1));
		write_register(REG_RECT_INDEX, 32'h0000_FFFF);
		write_register(REG_DUTY_OFFSET, 32'h0000_0000);
		send_item(tick_item(16'd16384, 1'b1));
		send_item(tick_item(16'hFFFF, 1'b0));
		write_register(REG_RECT_INDEX, 32'h0000_0000);
		write_register(REG_DUTY_OFFSET, 32'h0000_FFFF);
		send_item(tick_item(16'hFFFF, 1'b1));
		send_item(tick_item(16'h0001, 1'b0));
		write_register(REG_PHASE_STEP, 32'h0000_0000);
		write_register(REG_DUTY_OFFSET, 32'd32768);
	endtask

	// spare code and loads past the table end must change nothing
	task automatic test_ignored_items;
		send_item(load_item(MODE_SPARE, 0, 16'h1234));
		send_item(load_item(MODE_SINE, TABLE_LEN, 16'h7FFF));
		send_item(load_item(MODE_HARM, 2047, 16'h8000));
		send_item(load_item(MODE_SINE, TABLE_LEN + THIRD_TURN, 16'h8000));
		send_item(tick_item(16'd20000, 1'b0));
		send_item(tick_item(16'd20000, 1'b1));
	endtask

	// random traffic under a series of register settings
	task automatic test_random_traffic;
		int counted;
		bit paused;
		spwm_item_t it;
		paused = 1'b0;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
			0: begin
				// one sixteenth of a turn per tick
				write_register(REG_PHASE_STEP, 32'h1000_0000);
				write_register(REG_RECT_INDEX, $urandom_range(0, 65535));
				write_register(REG_DUTY_OFFSET, PHASE_W'(DUTY_OFFSET_RST));
			end
			1: begin
				write_register(REG_PHASE_STEP, pick_step());
				write_register(REG_RECT_INDEX, 32'h0000_0000);
				write_register(REG_DUTY_OFFSET, 32'd32768);
			end
			2: begin
				write_register(REG_PHASE_STEP, 32'h5000_0000);
				write_register(REG_RECT_INDEX, 32'h0000_FFFF);
				write_register(REG_DUTY_OFFSET, 32'h0000_0000);
			end
			3: begin
				// backwards by a sixteenth, wrapping through zero
				write_register(REG_PHASE_STEP, 32'hF000_0000);
				write_register(REG_RECT_INDEX, 32'd16384);
				write_register(REG_DUTY_OFFSET, 32'h0000_FFFF);
			end
			4: begin
				write_register(REG_PHASE_STEP, pick_step());
				write_register(REG_RECT_INDEX, $urandom_range(0, 65535));
				write_register(REG_DUTY_OFFSET, $urandom_range(0, 65535));
			end
			default: begin
				write_register(REG_PHASE_STEP, pick_step());
				write_register(REG_RECT_INDEX, $urandom_range(0, 65535));
				write_register(REG_DUTY_OFFSET, $urandom_range(0, 65535));
			end
			endcase
			counted = 0;
			while (counted < SEGMENT_ITEMS) begin
				it = random_item();
				send_item(it);
				if (!(it.mode == MODE_SPARE || (it.mode != MODE_TICK && it.addr >= TABLE_LEN)))
					counted++;
				// hold the sender until every duty is home
				if (seg == 2 && counted == 40 && !paused) begin
					paused = 1'b1;
					release_input();
					await_quiet();
				end
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_index_wrap_and_saturation();
		test_ignored_items();
		test_random_traffic();
		release_input();
		await_quiet();
		if (error_count == 0) begin
			$display("[three_phase_spwm_third_harmonic_core] OK");
		end else begin
			$display("[three_phase_spwm_third_harmonic_core] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("[three_phase_spwm_third_harmonic_core] ERROR");
		$finish;
	end

endmodule
